// ===== sv/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher package
// Shared sizes, codes and record types of the order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

    // Book geometry and field widths.
    localparam int ORDER_SLOTS  = 64;
    localparam int PRICE_LEVELS = 1024;
    localparam int SLOT_W       = $clog2(ORDER_SLOTS);
    localparam int TICK_W       = $clog2(PRICE_LEVELS);
    localparam int QTY_W        = 24;
    localparam int VOL_W        = 30;
    localparam int CNT_W        = $clog2(ORDER_SLOTS + 1);

    // Input commands.
    typedef enum logic [1:0] {
        CMD_LIMIT  = 2'd0,
        CMD_MARKET = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    // Final status codes.
    typedef enum logic [2:0] {
        ST_RESTED    = 3'd0,
        ST_FILLED    = 3'd1,
        ST_ZERO_QTY  = 3'd2,
        ST_DUP_ID    = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_MKT_REM   = 3'd6,
        ST_VOLUME    = 3'd7
    } t_status;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LVL_RD,
        S_LVL_CHK,
        S_SLOT,
        S_UNLINK,
        S_UNLINK2,
        S_NEXT,
        S_POST,
        S_APPEND,
        S_APPEND2,
        S_CXL_SLOT,
        S_CXL_LVL,
        S_Q_LVL,
        S_Q_SLOT,
        S_FINISH
    } t_state;

    // One resting order slot.
    typedef struct packed {
        logic              side;
        logic [TICK_W-1:0] price;
        logic [QTY_W-1:0]  qty;
        logic [SLOT_W-1:0] next;
        logic [SLOT_W-1:0] prev;
    } t_slot;

    // One price level queue descriptor.
    typedef struct packed {
        logic              nonempty;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_level;

    // A trade waiting to be reported.
    typedef struct packed {
        logic [SLOT_W-1:0] buyer;
        logic [SLOT_W-1:0] seller;
        logic [TICK_W-1:0] tick;
        logic [QTY_W-1:0]  tqty;
        logic [QTY_W-1:0]  rem;
    } t_trade;

    // One result transaction.
    typedef struct packed {
        logic              is_trade;
        logic [SLOT_W-1:0] buyer;
        logic [SLOT_W-1:0] seller;
        logic [TICK_W-1:0] tick;
        logic [QTY_W-1:0]  tqty;
        logic [QTY_W-1:0]  rem;
        logic [VOL_W-1:0]  vol;
        logic [2:0]        status;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority book over a slot memory and a price level memory.
// ----------------------------------------------------------------------------
// Busy: a command holds busy while the sweep scans price levels and visits
//   resting orders, or while a query sums the orders of its level; the sweep
//   stops early once the opposite side is empty.
// Throughput: one command at a time; the final result is shown in the same cycle
//   that busy falls, and the memory walk sets the rate. Results cannot be stalled.
// Reset: a clearing pass over every price level empties the level memory, busy is high.
`default_nettype none

module limit_order_book_matcher (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_command,
    input  wire logic [lobm_pkg::SLOT_W-1:0]  i_order_id,
    input  wire logic                         i_buy_side,
    input  wire logic [lobm_pkg::TICK_W-1:0]  i_price_tick,
    input  wire logic [lobm_pkg::QTY_W-1:0]   i_quantity,
    output logic                              o_valid,
    output logic                              o_is_trade,
    output logic [lobm_pkg::SLOT_W-1:0]       o_buyer_id,
    output logic [lobm_pkg::SLOT_W-1:0]       o_seller_id,
    output logic [lobm_pkg::TICK_W-1:0]       o_trade_price_tick,
    output logic [lobm_pkg::QTY_W-1:0]        o_trade_qty,
    output logic [lobm_pkg::QTY_W-1:0]        o_remaining_qty,
    output logic [lobm_pkg::VOL_W-1:0]        o_level_volume,
    output logic [2:0]                        o_status,
    output logic                              o_last
);

    localparam logic [lobm_pkg::TICK_W-1:0] TOP_TICK =
        lobm_pkg::TICK_W'(lobm_pkg::PRICE_LEVELS - 1);

    // Memories and their ports.
    lobm_pkg::t_slot  r_sl_mem [lobm_pkg::ORDER_SLOTS];
    lobm_pkg::t_level r_lv_mem [lobm_pkg::PRICE_LEVELS];
    lobm_pkg::t_slot  r_sl_rd;
    lobm_pkg::t_level r_lv_rd;

    logic [lobm_pkg::SLOT_W-1:0] sl_raddr;
    logic [lobm_pkg::SLOT_W-1:0] sl_waddr;
    lobm_pkg::t_slot             sl_wdata;
    logic                        sl_we_sp;
    logic                        sl_we_qty;
    logic                        sl_we_next;
    logic                        sl_we_prev;
    logic [lobm_pkg::TICK_W-1:0] lv_raddr;
    logic [lobm_pkg::TICK_W-1:0] lv_waddr;
    lobm_pkg::t_level            lv_wdata;
    logic                        lv_we;

    // Control and working registers.
    lobm_pkg::t_state r_state, n_state;
    lobm_pkg::t_cmd   r_cmd, n_cmd;
    lobm_pkg::t_status r_status, n_status;
    logic [lobm_pkg::SLOT_W-1:0] r_id, n_id;
    logic                        r_buy, n_buy;
    logic [lobm_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [lobm_pkg::QTY_W-1:0]  r_qty, n_qty;
    logic [lobm_pkg::TICK_W-1:0] r_bound, n_bound;
    logic [lobm_pkg::TICK_W-1:0] r_lvl, n_lvl;
    logic [lobm_pkg::TICK_W-1:0] r_laddr, n_laddr;
    logic [lobm_pkg::SLOT_W-1:0] r_cur, n_cur;
    logic [lobm_pkg::SLOT_W-1:0] r_snext, n_snext;
    logic [lobm_pkg::SLOT_W-1:0] r_sprev, n_sprev;
    logic [lobm_pkg::SLOT_W-1:0] r_lhead, n_lhead;
    logic [lobm_pkg::SLOT_W-1:0] r_ltail, n_ltail;
    logic                        r_at_end, n_at_end;
    logic [lobm_pkg::VOL_W-1:0]  r_vol, n_vol;
    lobm_pkg::t_trade            r_pend, n_pend;
    logic                        r_pend_v, n_pend_v;
    logic [lobm_pkg::ORDER_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [lobm_pkg::CNT_W-1:0]  r_n_buy, n_n_buy;
    logic [lobm_pkg::CNT_W-1:0]  r_n_sell, n_n_sell;
    logic [lobm_pkg::TICK_W-1:0] r_clr, n_clr;
    lobm_pkg::t_result           r_out, n_out;
    logic                        r_out_v, n_out_v;

    logic [lobm_pkg::CNT_W-1:0]  opp_cnt;
    logic [lobm_pkg::QTY_W-1:0]  trade_qty;
    logic [lobm_pkg::QTY_W-1:0]  left_qty;
    logic [lobm_pkg::QTY_W-1:0]  rest_qty;

    assign busy    = (r_state != lobm_pkg::S_IDLE);
    assign opp_cnt = r_buy ? r_n_sell : r_n_buy;

    // Trade arithmetic on the slot just read.
    assign trade_qty = (r_qty < r_sl_rd.qty) ? r_qty : r_sl_rd.qty;
    assign left_qty  = r_qty - trade_qty;
    assign rest_qty  = r_sl_rd.qty - trade_qty;

    // Slot memory: one read and one field-masked write per cycle.
    always_ff @(posedge i_clk) begin
        if (sl_we_sp) begin
            r_sl_mem[sl_waddr].side  <= sl_wdata.side;
            r_sl_mem[sl_waddr].price <= sl_wdata.price;
        end
        if (sl_we_qty) begin
            r_sl_mem[sl_waddr].qty <= sl_wdata.qty;
        end
        if (sl_we_next) begin
            r_sl_mem[sl_waddr].next <= sl_wdata.next;
        end
        if (sl_we_prev) begin
            r_sl_mem[sl_waddr].prev <= sl_wdata.prev;
        end
        r_sl_rd <= r_sl_mem[sl_raddr];
    end

    // Level memory: one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (lv_we) begin
            r_lv_mem[lv_waddr] <= lv_wdata;
        end
        r_lv_rd <= r_lv_mem[lv_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lobm_pkg::S_CLEAR;
            r_clr        <= '0;
            r_slot_valid <= '0;
            r_n_buy      <= '0;
            r_n_sell     <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_slot_valid <= n_slot_valid;
            r_n_buy      <= n_n_buy;
            r_n_sell     <= n_n_sell;
            r_pend_v     <= n_pend_v;
            r_out_v      <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_id     <= n_id;
        r_buy    <= n_buy;
        r_tick   <= n_tick;
        r_qty    <= n_qty;
        r_bound  <= n_bound;
        r_lvl    <= n_lvl;
        r_laddr  <= n_laddr;
        r_cur    <= n_cur;
        r_snext  <= n_snext;
        r_sprev  <= n_sprev;
        r_lhead  <= n_lhead;
        r_ltail  <= n_ltail;
        r_at_end <= n_at_end;
        r_vol    <= n_vol;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    // Sequencer: next state, memory accesses and results.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_id         = r_id;
        n_buy        = r_buy;
        n_tick       = r_tick;
        n_qty        = r_qty;
        n_bound      = r_bound;
        n_lvl        = r_lvl;
        n_laddr      = r_laddr;
        n_cur        = r_cur;
        n_snext      = r_snext;
        n_sprev      = r_sprev;
        n_lhead      = r_lhead;
        n_ltail      = r_ltail;
        n_at_end     = r_at_end;
        n_vol        = r_vol;
        n_pend       = r_pend;
        n_pend_v     = r_pend_v;
        n_slot_valid = r_slot_valid;
        n_n_buy      = r_n_buy;
        n_n_sell     = r_n_sell;
        n_clr        = r_clr;
        n_out        = r_out;
        n_out_v      = 1'b0;

        sl_raddr   = r_cur;
        sl_waddr   = r_cur;
        sl_wdata   = '0;
        sl_we_sp   = 1'b0;
        sl_we_qty  = 1'b0;
        sl_we_next = 1'b0;
        sl_we_prev = 1'b0;
        lv_raddr   = r_lvl;
        lv_waddr   = r_laddr;
        lv_wdata   = '0;
        lv_we      = 1'b0;

        case (r_state)
            // Empty every price level after reset.
            lobm_pkg::S_CLEAR: begin
                lv_we    = 1'b1;
                lv_waddr = r_clr;
                n_clr    = r_clr + lobm_pkg::TICK_W'(1);
                if (r_clr == TOP_TICK) begin
                    n_state = lobm_pkg::S_IDLE;
                end
            end

            // Take a command transaction.
            lobm_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd    = lobm_pkg::t_cmd'(i_command);
                    n_id     = i_order_id;
                    n_buy    = i_buy_side;
                    n_tick   = i_price_tick;
                    n_qty    = i_quantity;
                    n_vol    = '0;
                    n_pend_v = 1'b0;
                    n_state  = lobm_pkg::S_DECODE;
                end
            end

            lobm_pkg::S_DECODE: begin
                case (r_cmd)
                    lobm_pkg::CMD_QUERY: begin
                        lv_raddr = r_tick;
                        n_qty    = '0;
                        n_state  = lobm_pkg::S_Q_LVL;
                    end
                    lobm_pkg::CMD_CANCEL: begin
                        n_qty = '0;
                        if (!r_slot_valid[r_id]) begin
                            n_status = lobm_pkg::ST_NOT_FOUND;
                            n_state  = lobm_pkg::S_FINISH;
                        end else begin
                            sl_raddr = r_id;
                            n_cur    = r_id;
                            n_state  = lobm_pkg::S_CXL_SLOT;
                        end
                    end
                    default: begin
                        if (r_qty == '0) begin
                            n_status = lobm_pkg::ST_ZERO_QTY;
                            n_state  = lobm_pkg::S_FINISH;
                        end else if (r_cmd == lobm_pkg::CMD_LIMIT &&
                                     r_slot_valid[r_id]) begin
                            n_qty    = '0;
                            n_status = lobm_pkg::ST_DUP_ID;
                            n_state  = lobm_pkg::S_FINISH;
                        end else begin
                            if (r_cmd == lobm_pkg::CMD_MARKET) begin
                                n_bound = r_buy ? TOP_TICK : '0;
                            end else begin
                                n_bound = r_tick;
                            end
                            n_lvl   = r_buy ? '0 : TOP_TICK;
                            n_state = lobm_pkg::S_LVL_RD;
                        end
                    end
                endcase
            end

            // Fetch the next price level of the sweep.
            lobm_pkg::S_LVL_RD: begin
                if (r_qty == '0 || opp_cnt == '0) begin
                    n_state = lobm_pkg::S_POST;
                end else begin
                    lv_raddr = r_lvl;
                    n_laddr  = r_lvl;
                    n_state  = lobm_pkg::S_LVL_CHK;
                end
            end

            lobm_pkg::S_LVL_CHK: begin
                if (r_lv_rd.nonempty) begin
                    n_lhead  = r_lv_rd.head;
                    n_ltail  = r_lv_rd.tail;
                    n_cur    = r_lv_rd.head;
                    sl_raddr = r_lv_rd.head;
                    n_state  = lobm_pkg::S_SLOT;
                end else if (r_lvl == r_bound) begin
                    n_state = lobm_pkg::S_POST;
                end else begin
                    n_lvl   = r_buy ? r_lvl + lobm_pkg::TICK_W'(1)
                                    : r_lvl - lobm_pkg::TICK_W'(1);
                    n_state = lobm_pkg::S_LVL_RD;
                end
            end

            // Match against one resting order.
            lobm_pkg::S_SLOT: begin
                n_snext  = r_sl_rd.next;
                n_sprev  = r_sl_rd.prev;
                n_at_end = (r_cur == r_ltail);
                if (r_sl_rd.side == r_buy) begin
                    n_state = lobm_pkg::S_NEXT;
                end else begin
                    // The previous trade is now known not to be the last one.
                    if (r_pend_v) begin
                        n_out_v        = 1'b1;
                        n_out.is_trade = 1'b1;
                        n_out.buyer    = r_pend.buyer;
                        n_out.seller   = r_pend.seller;
                        n_out.tick     = r_pend.tick;
                        n_out.tqty     = r_pend.tqty;
                        n_out.rem      = r_pend.rem;
                        n_out.vol      = '0;
                        n_out.status   = '0;
                        n_out.last     = 1'b0;
                    end
                    n_qty         = left_qty;
                    n_pend_v      = 1'b1;
                    n_pend.buyer  = r_buy ? r_id : r_cur;
                    n_pend.seller = r_buy ? r_cur : r_id;
                    n_pend.tick   = r_lvl;
                    n_pend.tqty   = trade_qty;
                    n_pend.rem    = left_qty;
                    if (rest_qty == '0) begin
                        n_slot_valid[r_cur] = 1'b0;
                        if (r_sl_rd.side) begin
                            n_n_buy = r_n_buy - lobm_pkg::CNT_W'(1);
                        end else begin
                            n_n_sell = r_n_sell - lobm_pkg::CNT_W'(1);
                        end
                        n_state = lobm_pkg::S_UNLINK;
                    end else begin
                        sl_we_qty    = 1'b1;
                        sl_wdata.qty = rest_qty;
                        n_state      = lobm_pkg::S_NEXT;
                    end
                end
            end

            // Remove the current slot from its level queue.
            lobm_pkg::S_UNLINK: begin
                if (r_lhead == r_cur && r_ltail == r_cur) begin
                    lv_we    = 1'b1;
                    lv_wdata = '{nonempty: 1'b0, head: r_lhead, tail: r_ltail};
                end else if (r_lhead == r_cur) begin
                    lv_we    = 1'b1;
                    lv_wdata = '{nonempty: 1'b1, head: r_snext, tail: r_ltail};
                    n_lhead  = r_snext;
                end else if (r_ltail == r_cur) begin
                    lv_we    = 1'b1;
                    lv_wdata = '{nonempty: 1'b1, head: r_lhead, tail: r_sprev};
                    n_ltail  = r_sprev;
                end else begin
                    sl_we_next    = 1'b1;
                    sl_waddr      = r_sprev;
                    sl_wdata.next = r_snext;
                end
                if (r_lhead != r_cur && r_ltail != r_cur) begin
                    n_state = lobm_pkg::S_UNLINK2;
                end else if (r_cmd == lobm_pkg::CMD_CANCEL) begin
                    n_status = lobm_pkg::ST_CANCELLED;
                    n_state  = lobm_pkg::S_FINISH;
                end else begin
                    n_state = lobm_pkg::S_NEXT;
                end
            end

            // Second half of a mid-queue unlink.
            lobm_pkg::S_UNLINK2: begin
                sl_we_prev    = 1'b1;
                sl_waddr      = r_snext;
                sl_wdata.prev = r_sprev;
                if (r_cmd == lobm_pkg::CMD_CANCEL) begin
                    n_status = lobm_pkg::ST_CANCELLED;
                    n_state  = lobm_pkg::S_FINISH;
                end else begin
                    n_state = lobm_pkg::S_NEXT;
                end
            end

            // Step along the queue or on to the next level.
            lobm_pkg::S_NEXT: begin
                if (r_qty == '0) begin
                    n_state = lobm_pkg::S_POST;
                end else if (!r_at_end) begin
                    n_cur    = r_snext;
                    sl_raddr = r_snext;
                    n_state  = lobm_pkg::S_SLOT;
                end else if (r_lvl == r_bound) begin
                    n_state = lobm_pkg::S_POST;
                end else begin
                    n_lvl   = r_buy ? r_lvl + lobm_pkg::TICK_W'(1)
                                    : r_lvl - lobm_pkg::TICK_W'(1);
                    n_state = lobm_pkg::S_LVL_RD;
                end
            end

            // Sweep done: report or rest the remainder.
            lobm_pkg::S_POST: begin
                if (r_cmd == lobm_pkg::CMD_MARKET) begin
                    n_status = (r_qty != '0) ? lobm_pkg::ST_MKT_REM
                                             : lobm_pkg::ST_FILLED;
                    n_state  = lobm_pkg::S_FINISH;
                end else if (r_qty == '0) begin
                    n_status = lobm_pkg::ST_FILLED;
                    n_state  = lobm_pkg::S_FINISH;
                end else begin
                    lv_raddr = r_tick;
                    n_laddr  = r_tick;
                    n_state  = lobm_pkg::S_APPEND;
                end
            end

            // Append the new order at the tail of its level.
            lobm_pkg::S_APPEND: begin
                sl_we_sp       = 1'b1;
                sl_we_qty      = 1'b1;
                sl_we_prev     = 1'b1;
                sl_waddr       = r_id;
                sl_wdata.side  = r_buy;
                sl_wdata.price = r_tick;
                sl_wdata.qty   = r_qty;
                sl_wdata.prev  = r_lv_rd.tail;
                n_slot_valid[r_id] = 1'b1;
                if (r_buy) begin
                    n_n_buy = r_n_buy + lobm_pkg::CNT_W'(1);
                end else begin
                    n_n_sell = r_n_sell + lobm_pkg::CNT_W'(1);
                end
                lv_we = 1'b1;
                if (!r_lv_rd.nonempty) begin
                    lv_wdata = '{nonempty: 1'b1, head: r_id, tail: r_id};
                    n_status = lobm_pkg::ST_RESTED;
                    n_state  = lobm_pkg::S_FINISH;
                end else begin
                    lv_wdata = '{nonempty: 1'b1, head: r_lv_rd.head, tail: r_id};
                    n_sprev  = r_lv_rd.tail;
                    n_state  = lobm_pkg::S_APPEND2;
                end
            end

            lobm_pkg::S_APPEND2: begin
                sl_we_next    = 1'b1;
                sl_waddr      = r_sprev;
                sl_wdata.next = r_id;
                n_status      = lobm_pkg::ST_RESTED;
                n_state       = lobm_pkg::S_FINISH;
            end

            // Cancel: slot read back, then its level.
            lobm_pkg::S_CXL_SLOT: begin
                n_snext  = r_sl_rd.next;
                n_sprev  = r_sl_rd.prev;
                n_laddr  = r_sl_rd.price;
                lv_raddr = r_sl_rd.price;
                n_slot_valid[r_id] = 1'b0;
                if (r_sl_rd.side) begin
                    n_n_buy = r_n_buy - lobm_pkg::CNT_W'(1);
                end else begin
                    n_n_sell = r_n_sell - lobm_pkg::CNT_W'(1);
                end
                n_state = lobm_pkg::S_CXL_LVL;
            end

            lobm_pkg::S_CXL_LVL: begin
                n_lhead = r_lv_rd.head;
                n_ltail = r_lv_rd.tail;
                n_state = lobm_pkg::S_UNLINK;
            end

            // Volume query: walk the level queue and add up quantities.
            lobm_pkg::S_Q_LVL: begin
                if (!r_lv_rd.nonempty) begin
                    n_status = lobm_pkg::ST_VOLUME;
                    n_state  = lobm_pkg::S_FINISH;
                end else begin
                    n_cur    = r_lv_rd.head;
                    n_ltail  = r_lv_rd.tail;
                    sl_raddr = r_lv_rd.head;
                    n_state  = lobm_pkg::S_Q_SLOT;
                end
            end

            lobm_pkg::S_Q_SLOT: begin
                n_vol = r_vol + lobm_pkg::VOL_W'(r_sl_rd.qty);
                if (r_cur == r_ltail) begin
                    n_status = lobm_pkg::ST_VOLUME;
                    n_state  = lobm_pkg::S_FINISH;
                end else begin
                    n_cur    = r_sl_rd.next;
                    sl_raddr = r_sl_rd.next;
                end
            end

            // Final result transaction of the command.
            lobm_pkg::S_FINISH: begin
                n_out_v      = 1'b1;
                n_out.status = r_status;
                n_out.last   = 1'b1;
                if (r_pend_v) begin
                    n_out.is_trade = 1'b1;
                    n_out.buyer    = r_pend.buyer;
                    n_out.seller   = r_pend.seller;
                    n_out.tick     = r_pend.tick;
                    n_out.tqty     = r_pend.tqty;
                    n_out.rem      = r_pend.rem;
                    n_out.vol      = '0;
                end else begin
                    n_out.is_trade = 1'b0;
                    n_out.buyer    = '0;
                    n_out.seller   = '0;
                    n_out.tick     = '0;
                    n_out.tqty     = '0;
                    n_out.rem      = r_qty;
                    n_out.vol      = r_vol;
                end
                n_pend_v = 1'b0;
                n_state  = lobm_pkg::S_IDLE;
            end

            default: begin
                n_state = lobm_pkg::S_IDLE;
            end
        endcase
    end

    // Result ports.
    assign o_valid            = r_out_v;
    assign o_is_trade         = r_out.is_trade;
    assign o_buyer_id         = r_out.buyer;
    assign o_seller_id        = r_out.seller;
    assign o_trade_price_tick = r_out.tick;
    assign o_trade_qty        = r_out.tqty;
    assign o_remaining_qty    = r_out.rem;
    assign o_level_volume     = r_out.vol;
    assign o_status           = r_out.status;
    assign o_last             = r_out.last;

    // The side counters always agree with the slot valid bits.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == (32'(r_n_buy) + 32'(r_n_sell)))
        else $error("side counters disagree with slot valid bits");

    // Only trades may be followed by more results of the same command.
    a_nonlast_trade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_is_trade)
        else $error("non-final result that is no trade");

    // The final result is shown once the block is ready again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("final result while still busy");

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

endmodule

`default_nettype wire

// ===== tb/sv/tb_limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// Limit order book matcher testbench
// Drives limit, market, cancel and volume query commands into the matcher and
// checks every result against a price-time priority book model kept here.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_limit_order_book_matcher;

    localparam int CYCLE_LIMIT = 4000000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [1:0]                    i_command;
    logic [lobm_pkg::SLOT_W-1:0]   i_order_id;
    logic                          i_buy_side;
    logic [lobm_pkg::TICK_W-1:0]   i_price_tick;
    logic [lobm_pkg::QTY_W-1:0]    i_quantity;
    logic                          o_valid;
    logic                          o_is_trade;
    logic [lobm_pkg::SLOT_W-1:0]   o_buyer_id;
    logic [lobm_pkg::SLOT_W-1:0]   o_seller_id;
    logic [lobm_pkg::TICK_W-1:0]   o_trade_price_tick;
    logic [lobm_pkg::QTY_W-1:0]    o_trade_qty;
    logic [lobm_pkg::QTY_W-1:0]    o_remaining_qty;
    logic [lobm_pkg::VOL_W-1:0]    o_level_volume;
    logic [2:0]                    o_status;
    logic                          o_last;

    limit_order_book_matcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_order_id         (i_order_id),
        .i_buy_side         (i_buy_side),
        .i_price_tick       (i_price_tick),
        .i_quantity         (i_quantity),
        .o_valid            (o_valid),
        .o_is_trade         (o_is_trade),
        .o_buyer_id         (o_buyer_id),
        .o_seller_id        (o_seller_id),
        .o_trade_price_tick (o_trade_price_tick),
        .o_trade_qty        (o_trade_qty),
        .o_remaining_qty    (o_remaining_qty),
        .o_level_volume     (o_level_volume),
        .o_status           (o_status),
        .o_last             (o_last)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow book: slots, per-level FIFO queues of slot ids.
    logic                        book_valid [lobm_pkg::ORDER_SLOTS];
    logic                        book_side  [lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::TICK_W-1:0] book_price [lobm_pkg::ORDER_SLOTS];
    logic [lobm_pkg::QTY_W-1:0]  book_qty   [lobm_pkg::ORDER_SLOTS];
    int                          level_queue [lobm_pkg::PRICE_LEVELS][$];

    lobm_pkg::t_result expected_results [$];
    int                error_count;
    bit                allow_gaps;
    longint            cycle_count;

    // Adds one expected result at the end of the queue.
    function automatic void queue_result(lobm_pkg::t_result r);
        expected_results = {expected_results, r};
    endfunction

    // Removes one slot id from its level queue.
    function automatic void drop_from_level(int s);
        int p;
        p = book_price[s];
        for (int k = 0; k < level_queue[p].size(); k++) begin
            if (level_queue[p][k] == s) begin
                level_queue[p].delete(k);
                break;
            end
        end
    endfunction

    function automatic lobm_pkg::t_result idle_result(logic [lobm_pkg::QTY_W-1:0] rem,
                                                      lobm_pkg::t_status st);
        lobm_pkg::t_result r;
        r = '0;
        r.rem = rem;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    // Walks the opposite side from the best tick up to the bound.
    function automatic void match_sweep(logic buy, logic [lobm_pkg::SLOT_W-1:0] id,
                                        int bound, ref logic [lobm_pkg::QTY_W-1:0] qty,
                                        ref lobm_pkg::t_result trades [$]);
        int span;
        int lv;
        int s;
        int k;
        logic [lobm_pkg::QTY_W-1:0] fill;
        lobm_pkg::t_result r;
        span = buy ? bound + 1 : lobm_pkg::PRICE_LEVELS - bound;
        for (int n = 0; n < span && qty > 0; n++) begin
            lv = buy ? n : lobm_pkg::PRICE_LEVELS - 1 - n;
            k = 0;
            while (k < level_queue[lv].size() && qty > 0 &&
                   trades.size() < lobm_pkg::ORDER_SLOTS) begin
                s = level_queue[lv][k];
                if (book_side[s] != buy) begin
                    fill = (qty < book_qty[s]) ? qty : book_qty[s];
                    qty -= fill;
                    book_qty[s] -= fill;
                    r = '0;
                    r.is_trade = 1'b1;
                    r.buyer = buy ? id : lobm_pkg::SLOT_W'(s);
                    r.seller = buy ? lobm_pkg::SLOT_W'(s) : id;
                    r.tick = lobm_pkg::TICK_W'(lv);
                    r.tqty = fill;
                    r.rem = qty;
                    trades = {trades, r};
                    if (book_qty[s] == 0) begin
                        book_valid[s] = 1'b0;
                        level_queue[lv].delete(k);
                        continue;
                    end
                end
                k++;
            end
        end
    endfunction

    // Applies one command to the shadow book and queues its results.
    function automatic void predict_book(lobm_pkg::t_cmd cmd,
                                         logic [lobm_pkg::SLOT_W-1:0] id, logic buy,
                                         logic [lobm_pkg::TICK_W-1:0] tick,
                                         logic [lobm_pkg::QTY_W-1:0] qty);
        lobm_pkg::t_result trades [$];
        lobm_pkg::t_status st;
        logic [lobm_pkg::VOL_W-1:0] vol;
        lobm_pkg::t_result r;
        case (cmd)
            lobm_pkg::CMD_QUERY: begin
                vol = '0;
                for (int k = 0; k < level_queue[tick].size(); k++) begin
                    vol += lobm_pkg::VOL_W'(book_qty[level_queue[tick][k]]);
                end
                r = idle_result('0, lobm_pkg::ST_VOLUME);
                r.vol = vol;
                queue_result(r);
                return;
            end
            lobm_pkg::CMD_CANCEL: begin
                if (!book_valid[id]) begin
                    queue_result(idle_result('0, lobm_pkg::ST_NOT_FOUND));
                end else begin
                    drop_from_level(id);
                    book_valid[id] = 1'b0;
                    queue_result(idle_result('0, lobm_pkg::ST_CANCELLED));
                end
                return;
            end
            default: ;
        endcase
        if (qty == 0) begin
            queue_result(idle_result('0, lobm_pkg::ST_ZERO_QTY));
            return;
        end
        if (cmd == lobm_pkg::CMD_MARKET) begin
            match_sweep(buy, id, buy ? lobm_pkg::PRICE_LEVELS - 1 : 0, qty, trades);
            st = (qty > 0) ? lobm_pkg::ST_MKT_REM : lobm_pkg::ST_FILLED;
        end else if (book_valid[id]) begin
            queue_result(idle_result('0, lobm_pkg::ST_DUP_ID));
            return;
        end else begin
            match_sweep(buy, id, tick, qty, trades);
            if (qty > 0) begin
                book_valid[id] = 1'b1;
                book_side[id] = buy;
                book_price[id] = tick;
                book_qty[id] = qty;
                level_queue[tick] = {level_queue[tick], int'(id)};
                st = lobm_pkg::ST_RESTED;
            end else begin
                st = lobm_pkg::ST_FILLED;
            end
        end
        if (trades.size() == 0) begin
            queue_result(idle_result(qty, st));
        end else begin
            trades[$].status = st;
            trades[$].last = 1'b1;
            foreach (trades[k]) queue_result(trades[k]);
        end
    endfunction

    // Sends one command transaction, with an optional random gap first.
    task automatic send_command(lobm_pkg::t_cmd cmd, logic [lobm_pkg::SLOT_W-1:0] id,
                                logic buy, logic [lobm_pkg::TICK_W-1:0] tick,
                                logic [lobm_pkg::QTY_W-1:0] qty);
        int gap;
        gap = (allow_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        repeat (gap) @(posedge i_clk);
        start        <= 1'b1;
        i_command    <= cmd;
        i_order_id   <= id;
        i_buy_side   <= buy;
        i_price_tick <= tick;
        i_quantity   <= qty;
        do @(posedge i_clk); while (busy);
        predict_book(cmd, id, buy, tick, qty);
        start <= 1'b0;
        // Let the block pick up the command before the next one.
        @(posedge i_clk);
    endtask

    // Checks each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        lobm_pkg::t_result want;
        lobm_pkg::t_result got;
        if (i_rst_n && o_valid) begin
            got = {o_is_trade, o_buyer_id, o_seller_id, o_trade_price_tick, o_trade_qty,
                   o_remaining_qty, o_level_volume, o_status, o_last};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.is_trade !== want.is_trade || got.buyer !== want.buyer ||
                    got.seller !== want.seller || got.tick !== want.tick ||
                    got.tqty !== want.tqty || got.rem !== want.rem ||
                    got.vol !== want.vol || got.status !== want.status ||
                    got.last !== want.last) begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want, got);
                    error_count++;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [lobm_pkg::SLOT_W-1:0] pick_slot(bit want_busy);
        int s;
        for (int tries = 0; tries < 64; tries++) begin
            s = $urandom_range(0, lobm_pkg::ORDER_SLOTS - 1);
            if (book_valid[s] == want_busy) return lobm_pkg::SLOT_W'(s);
        end
        return lobm_pkg::SLOT_W'(s);
    endfunction

    // Extremes, each command and each rejection path.
    task automatic test_directed();
        send_command(lobm_pkg::CMD_QUERY, 6'd0, 1'b0, 10'd1023, '0);
        send_command(lobm_pkg::CMD_LIMIT, 6'd0, 1'b1, 10'd5, 24'd0);
        send_command(lobm_pkg::CMD_MARKET, 6'd63, 1'b1, 10'd0, 24'hFFFFFF);
        send_command(lobm_pkg::CMD_LIMIT, 6'd63, 1'b0, 10'd1023, 24'hFFFFFF);
        send_command(lobm_pkg::CMD_LIMIT, 6'd1, 1'b0, 10'd1023, 24'd10);
        send_command(lobm_pkg::CMD_LIMIT, 6'd2, 1'b1, 10'd0, 24'd7);
        send_command(lobm_pkg::CMD_LIMIT, 6'd3, 1'b1, 10'd0, 24'd3);
        send_command(lobm_pkg::CMD_QUERY, 6'd0, 1'b0, 10'd0, '0);
        send_command(lobm_pkg::CMD_LIMIT, 6'd1, 1'b1, 10'd20, 24'd4);
        send_command(lobm_pkg::CMD_LIMIT, 6'd4, 1'b0, 10'd0, 24'd12);
        send_command(lobm_pkg::CMD_CANCEL, 6'd5, 1'b0, 10'd0, '0);
        send_command(lobm_pkg::CMD_CANCEL, 6'd63, 1'b0, 10'd0, '0);
        send_command(lobm_pkg::CMD_MARKET, 6'd1, 1'b1, 10'd1023, 24'd0);
        send_command(lobm_pkg::CMD_MARKET, 6'd63, 1'b1, 10'd1023, 24'h000100);
        send_command(lobm_pkg::CMD_LIMIT, 6'd10, 1'b1, 10'd512, 24'd50);
        send_command(lobm_pkg::CMD_LIMIT, 6'd11, 1'b1, 10'd512, 24'd60);
        send_command(lobm_pkg::CMD_LIMIT, 6'd12, 1'b1, 10'd512, 24'd70);
        send_command(lobm_pkg::CMD_CANCEL, 6'd11, 1'b0, 10'd0, '0);
        send_command(lobm_pkg::CMD_QUERY, 6'd0, 1'b1, 10'd512, '0);
        send_command(lobm_pkg::CMD_MARKET, 6'd10, 1'b0, 10'd0, 24'd500);
        send_command(lobm_pkg::CMD_QUERY, 6'd0, 1'b1, 10'd512, '0);
    endtask

    // Random traffic focused on a narrow band of ticks so orders cross.
    task automatic test_random(int count);
        int op;
        logic [lobm_pkg::TICK_W-1:0] tick;
        logic [lobm_pkg::QTY_W-1:0] qty;
        for (int n = 0; n < count; n++) begin
            allow_gaps = (n < count - 40);
            op = $urandom_range(0, 99);
            tick = ($urandom_range(0, 9) == 0) ? lobm_pkg::TICK_W'($urandom)
                                                : lobm_pkg::TICK_W'($urandom_range(500, 515));
            case ($urandom_range(0, 9))
                0:       qty = lobm_pkg::QTY_W'($urandom);
                1:       qty = '0;
                default: qty = lobm_pkg::QTY_W'($urandom_range(1, 200));
            endcase
            if (op < 50)
                send_command(lobm_pkg::CMD_LIMIT, pick_slot($urandom_range(0, 9) == 0),
                             1'($urandom), tick, qty);
            else if (op < 62)
                send_command(lobm_pkg::CMD_MARKET, lobm_pkg::SLOT_W'($urandom),
                             1'($urandom), tick, qty);
            else if (op < 82)
                send_command(lobm_pkg::CMD_CANCEL, pick_slot($urandom_range(0, 4) != 0),
                             1'($urandom), tick, lobm_pkg::QTY_W'($urandom));
            else
                send_command(lobm_pkg::CMD_QUERY, lobm_pkg::SLOT_W'($urandom),
                             1'($urandom), tick, lobm_pkg::QTY_W'($urandom));
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        allow_gaps = 1'b1;
        for (int s = 0; s < lobm_pkg::ORDER_SLOTS; s++) book_valid[s] = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = lobm_pkg::CMD_LIMIT;
        i_order_id   = '0;
        i_buy_side   = 1'b0;
        i_price_tick = '0;
        i_quantity   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(240);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/lobm_pkg.sv
sv/limit_order_book_matcher.sv
tb/sv/tb_limit_order_book_matcher.sv
